@@ rtl/pbfc_pkg.sv @@
package pbfc_pkg;

	localparam int COORD_W    = 16;
	localparam int NUM_PLANES = 6;
	localparam int PLANE_W    = 64;
	localparam int APB_ADDR_W = 6;
	localparam int Q_FRAC     = 14;
	localparam int PROD_W     = 2 * COORD_W;
	localparam int ACC_W      = PROD_W + 2;

	localparam logic signed [COORD_W-1:0] BOX_LOW_RESET  = 16'sh7FFF;
	localparam logic signed [COORD_W-1:0] BOX_HIGH_RESET = 16'sh8000;

	typedef enum logic [2:0] {
		REG_LEFT   = 3'd0,
		REG_RIGHT  = 3'd1,
		REG_BOTTOM = 3'd2,
		REG_TOP    = 3'd3,
		REG_NEAR   = 3'd4,
		REG_FAR    = 3'd5
	} reg_idx_t;

	typedef logic [PLANE_W-1:0] plane_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
		logic                      last_vertex;
	} vtx_t;

	typedef struct packed {
		logic                      visible;
		logic signed [COORD_W-1:0] min_x;
		logic signed [COORD_W-1:0] min_y;
		logic signed [COORD_W-1:0] min_z;
		logic signed [COORD_W-1:0] max_x;
		logic signed [COORD_W-1:0] max_y;
		logic signed [COORD_W-1:0] max_z;
	} box_out_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] lo_x;
		logic signed [COORD_W-1:0] lo_y;
		logic signed [COORD_W-1:0] lo_z;
		logic signed [COORD_W-1:0] hi_x;
		logic signed [COORD_W-1:0] hi_y;
		logic signed [COORD_W-1:0] hi_z;
	} box_t;

endpackage

@@ rtl/pbfc_plane_test.sv @@
module pbfc_plane_test
	import pbfc_pkg::*;
(
	input  logic   clk,
	input  logic   en,
	input  plane_t plane,
	input  box_t   box,
	output logic   pass
);

	logic signed [COORD_W-1:0] nx, ny, nz, d;
	logic signed [COORD_W-1:0] cx, cy, cz;
	logic signed [PROD_W-1:0]  px_s2, py_s2, pz_s2;
	logic signed [COORD_W-1:0] d_s2;
	logic signed [ACC_W-1:0]   acc;

	assign nx = signed'(plane[63:48]);
	assign ny = signed'(plane[47:32]);
	assign nz = signed'(plane[31:16]);
	assign d  = signed'(plane[15:0]);

	// pick the positive vertex per axis
	assign cx = nx[COORD_W-1] ? box.lo_x : box.hi_x;
	assign cy = ny[COORD_W-1] ? box.lo_y : box.hi_y;
	assign cz = nz[COORD_W-1] ? box.lo_z : box.hi_z;

	always_ff @(posedge clk) begin
		if (en) begin
			px_s2 <= PROD_W'(nx) * PROD_W'(cx);
			py_s2 <= PROD_W'(ny) * PROD_W'(cy);
			pz_s2 <= PROD_W'(nz) * PROD_W'(cz);
			d_s2  <= d;
		end
	end

	always_comb begin
		acc = ACC_W'(px_s2) + ACC_W'(py_s2) + ACC_W'(pz_s2)
			+ (ACC_W'(d_s2) <<< Q_FRAC);
		pass = ~acc[ACC_W-1];
	end

endmodule

@@ rtl/patch_bbox_frustum_cull.sv @@
// Path: a last vertex beat is registered through v_s1 and v_s2 into box_valid and its box beat.
// Throughput: one vertex per cycle unless box_ready stalls; non-last vertices produce no output beat.
// The box update runs at the input beat; the six plane tests use one registered
// multiplier stage followed by an add-and-sign stage.
// Reset: asynchronous, active low; planes clear to zero (all boxes visible),
// the running box empties and the pipeline drains.
module patch_bbox_frustum_cull
	import pbfc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [PLANE_W-1:0]    pwdata,
	output logic [PLANE_W-1:0]    prdata,
	output logic                  pready,
	input  logic                  vtx_valid,
	output logic                  vtx_ready,
	input  vtx_t                  vtx,
	output logic                  box_valid,
	input  logic                  box_ready,
	output box_out_t              box
);

	plane_t                 plane_q [NUM_PLANES];
	box_t                   box_q, box_nxt, box_s1, box_s2;
	logic                   v_s1, v_s2;
	logic                   out_free, s2_free, s1_free, vtx_beat;
	logic [NUM_PLANES-1:0]  pass;
	reg_idx_t               widx;
	box_out_t               box_q_out;

	assign pready = 1'b1;
	assign widx   = reg_idx_t'(paddr[5:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PLANES; i++) plane_q[i] <= '0;
		end else if (psel && penable && pwrite) begin
			case (widx)
				REG_LEFT:   plane_q[0] <= pwdata;
				REG_RIGHT:  plane_q[1] <= pwdata;
				REG_BOTTOM: plane_q[2] <= pwdata;
				REG_TOP:    plane_q[3] <= pwdata;
				REG_NEAR:   plane_q[4] <= pwdata;
				REG_FAR:    plane_q[5] <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (widx)
			REG_LEFT:   prdata = plane_q[0];
			REG_RIGHT:  prdata = plane_q[1];
			REG_BOTTOM: prdata = plane_q[2];
			REG_TOP:    prdata = plane_q[3];
			REG_NEAR:   prdata = plane_q[4];
			REG_FAR:    prdata = plane_q[5];
			default:    prdata = '0;
		endcase
	end

	assign out_free  = !box_valid || box_ready;
	assign s2_free   = !v_s2 || out_free;
	assign s1_free   = !v_s1 || s2_free;
	assign vtx_ready = s1_free;
	assign vtx_beat  = vtx_valid && vtx_ready;

	// fold the incoming vertex into the running box
	always_comb begin
		box_nxt.lo_x = (vtx.pos_x < box_q.lo_x) ? vtx.pos_x : box_q.lo_x;
		box_nxt.lo_y = (vtx.pos_y < box_q.lo_y) ? vtx.pos_y : box_q.lo_y;
		box_nxt.lo_z = (vtx.pos_z < box_q.lo_z) ? vtx.pos_z : box_q.lo_z;
		box_nxt.hi_x = (vtx.pos_x > box_q.hi_x) ? vtx.pos_x : box_q.hi_x;
		box_nxt.hi_y = (vtx.pos_y > box_q.hi_y) ? vtx.pos_y : box_q.hi_y;
		box_nxt.hi_z = (vtx.pos_z > box_q.hi_z) ? vtx.pos_z : box_q.hi_z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q <= '{BOX_LOW_RESET, BOX_LOW_RESET, BOX_LOW_RESET,
				BOX_HIGH_RESET, BOX_HIGH_RESET, BOX_HIGH_RESET};
		end else if (vtx_beat) begin
			if (vtx.last_vertex) begin
				box_q <= '{BOX_LOW_RESET, BOX_LOW_RESET, BOX_LOW_RESET,
					BOX_HIGH_RESET, BOX_HIGH_RESET, BOX_HIGH_RESET};
			end else begin
				box_q <= box_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			box_valid <= 1'b0;
		end else begin
			if (s1_free)  v_s1      <= vtx_beat && vtx.last_vertex;
			if (s2_free)  v_s2      <= v_s1;
			if (out_free) box_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free) box_s1 <= box_nxt;
		if (s2_free) box_s2 <= box_s1;
		if (out_free) box_q_out <= '{&pass, box_s2.lo_x, box_s2.lo_y, box_s2.lo_z,
			box_s2.hi_x, box_s2.hi_y, box_s2.hi_z};
	end

	assign box = box_q_out;

	for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
		pbfc_plane_test u_test (
			.clk   (clk),
			.en    (s2_free),
			.plane (plane_q[p]),
			.box   (box_s1),
			.pass  (pass[p])
		);
	end

endmodule

@@ dv/testbench.sv @@
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import pbfc_pkg::*;

	localparam int HOLD_CYCLES     = 300;
	localparam int DRAIN_CYCLES    = 8;
	localparam int STALL_LIMIT     = 2000;
	localparam int TARGET_VERTICES = 950;
	localparam int NUM_ADDR_SLOTS  = 1 << (APB_ADDR_W - 3);
	localparam int COORD_MAX       = 2 ** (COORD_W - 1) - 1;
	localparam int COORD_MIN       = -(2 ** (COORD_W - 1));

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef enum int {
		STYLE_CLUSTER,
		STYLE_WIDE,
		STYLE_EDGE
	} patch_style_t;

	typedef enum int {
		PLANES_ZERO,
		PLANES_FRUSTUM,
		PLANES_TILTED,
		PLANES_RANDOM,
		PLANES_EXTREME,
		PLANES_SPARSE
	} plane_mix_t;

	class bbox_cull_tracker;
		plane_t   planes[NUM_PLANES];
		coord_t   run_lo[3];
		coord_t   run_hi[3];
		box_out_t expected_boxes[$];
		int       errors;

		function new();
			foreach (planes[i])
				planes[i] = '0;
			clear_box();
			errors = 0;
		endfunction

		function void clear_box();
			for (int a = 0; a < 3; a++) begin
				run_lo[a] = BOX_LOW_RESET;
				run_hi[a] = BOX_HIGH_RESET;
			end
		endfunction

		function void set_plane(int idx, plane_t value);
			if (idx < NUM_PLANES)
				planes[idx] = value;
		endfunction

		function bit plane_passes(plane_t p);
			coord_t n[3];
			coord_t c;
			longint acc;
			n[0] = p[63:48];
			n[1] = p[47:32];
			n[2] = p[31:16];
			acc = longint'(coord_t'(p[15:0])) * (longint'(1) << Q_FRAC);
			for (int a = 0; a < 3; a++) begin
				c = (n[a] >= 0) ? run_hi[a] : run_lo[a];
				acc += longint'(n[a]) * longint'(c);
			end
			return acc >= 0;
		endfunction

		function void note_vertex(vtx_t v);
			coord_t   pos[3];
			box_out_t b;
			pos[0] = v.pos_x;
			pos[1] = v.pos_y;
			pos[2] = v.pos_z;
			for (int a = 0; a < 3; a++) begin
				if (pos[a] < run_lo[a])
					run_lo[a] = pos[a];
				if (pos[a] > run_hi[a])
					run_hi[a] = pos[a];
			end
			if (!v.last_vertex)
				return;
			b.visible = 1'b1;
			foreach (planes[i])
				if (!plane_passes(planes[i]))
					b.visible = 1'b0;
			b.min_x = run_lo[0];
			b.min_y = run_lo[1];
			b.min_z = run_lo[2];
			b.max_x = run_hi[0];
			b.max_y = run_hi[1];
			b.max_z = run_hi[2];
			expected_boxes = {expected_boxes, b};
			clear_box();
		endfunction

		function void compare_field(string name, logic signed [31:0] want,
				logic signed [31:0] got);
			if (want !== got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_box(box_out_t got);
			box_out_t want;
			if (expected_boxes.size() == 0) begin
				$error("box beat with no patch pending");
				errors++;
				return;
			end
			want = expected_boxes.pop_front();
			compare_field("visible", 32'(want.visible), 32'(got.visible));
			compare_field("min_x", 32'(want.min_x), 32'(got.min_x));
			compare_field("min_y", 32'(want.min_y), 32'(got.min_y));
			compare_field("min_z", 32'(want.min_z), 32'(got.min_z));
			compare_field("max_x", 32'(want.max_x), 32'(got.max_x));
			compare_field("max_y", 32'(want.max_y), 32'(got.max_y));
			compare_field("max_z", 32'(want.max_z), 32'(got.max_z));
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	plane_t                pwdata;
	plane_t                prdata;
	logic                  pready;
	logic                  vtx_valid;
	logic                  vtx_ready;
	vtx_t                  vtx;
	logic                  box_valid;
	logic                  box_ready;
	box_out_t              box;

	bbox_cull_tracker tracker = new();

	bit send_fast;
	bit burst;
	bit hold_go;
	int sent_vertices;
	int idle_cycles;

	patch_bbox_frustum_cull u_top (.*);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && vtx_valid && vtx_ready)
			tracker.note_vertex(vtx);
		if (arst_n && box_valid && box_ready)
			tracker.check_box(box);
	end

	always @(posedge clk) begin
		if ((vtx_valid && vtx_ready) || (box_valid && box_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		int stall;
		bit fast;
		bit hold_taken;
		box_ready <= 1'b0;
		fast = 1'b0;
		hold_taken = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 15) == 0)
				fast = !fast;
			if (hold_go && !hold_taken) begin
				stall = HOLD_CYCLES;
				hold_taken = 1'b1;
			end else begin
				stall = fast ? 0 : $urandom_range(0, 10);
			end
			if (stall > 0) begin
				box_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			box_ready <= 1'b1;
			do @(posedge clk); while (!(box_valid && box_ready));
		end
	end

	task automatic send_vertex(coord_t x, coord_t y, coord_t z, bit last);
		int   gap;
		vtx_t v;
		if ($urandom_range(0, 15) == 0)
			send_fast = !send_fast;
		gap = (send_fast || burst) ? 0 : $urandom_range(0, 10);
		v.pos_x = x;
		v.pos_y = y;
		v.pos_z = z;
		v.last_vertex = last;
		if (gap > 0) begin
			vtx_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		vtx <= v;
		vtx_valid <= 1'b1;
		do @(posedge clk); while (!(vtx_valid && vtx_ready));
		sent_vertices++;
	endtask

	task automatic settle();
		vtx_valid <= 1'b0;
		do @(posedge clk); while (tracker.expected_boxes.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(int idx, plane_t value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_ADDR_W'(idx * (PLANE_W / 8));
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tracker.set_plane(idx, value);
	endtask

	task automatic release_bus();
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic plane_t axis_plane(reg_idx_t idx, int r, bit tilt);
		int n[3];
		int axis;
		int sgn;
		int unit;
		unit = 1 << Q_FRAC;
		n = '{0, 0, 0};
		case (idx)
			REG_LEFT: begin
				axis = 0;
				sgn = 1;
			end
			REG_RIGHT: begin
				axis = 0;
				sgn = -1;
			end
			REG_BOTTOM: begin
				axis = 1;
				sgn = 1;
			end
			REG_TOP: begin
				axis = 1;
				sgn = -1;
			end
			REG_NEAR: begin
				axis = 2;
				sgn = 1;
			end
			default: begin
				axis = 2;
				sgn = -1;
			end
		endcase
		if (tilt) begin
			for (int a = 0; a < 3; a++)
				n[a] = int'($urandom_range(0, 8192)) - 4096;
			n[axis] = sgn * int'($urandom_range(unit / 2, COORD_MAX));
		end else begin
			n[axis] = sgn * unit;
		end
		return {16'(n[0]), 16'(n[1]), 16'(n[2]), 16'(r)};
	endfunction

	function automatic plane_t extreme_plane();
		case ($urandom_range(0, 3))
			0: return '1;
			1: return {4{16'h8000}};
			2: return {4{16'h7FFF}};
			default: return '0;
		endcase
	endfunction

	task automatic load_all(plane_t p);
		for (int i = 0; i < NUM_PLANES; i++)
			write_reg(i, p);
		release_bus();
	endtask

	task automatic load_planes(plane_mix_t mix, int r);
		plane_t p;
		for (int i = 0; i < NUM_PLANES; i++) begin
			case (mix)
				PLANES_ZERO:     p = '0;
				PLANES_FRUSTUM:  p = axis_plane(reg_idx_t'(i), r, 1'b0);
				PLANES_TILTED:   p = axis_plane(reg_idx_t'(i), r, 1'b1);
				PLANES_RANDOM:   p = {$urandom, $urandom};
				PLANES_EXTREME:  p = extreme_plane();
				default:         p = $urandom_range(0, 1) ? '0 : {$urandom, $urandom};
			endcase
			write_reg(i, p);
		end
		if ($urandom_range(0, 1))
			write_reg(NUM_PLANES + $urandom_range(0, NUM_ADDR_SLOTS - NUM_PLANES - 1),
					{$urandom, $urandom});
		release_bus();
	endtask

	function automatic coord_t pick_coord(patch_style_t style, coord_t center, int spread);
		int v;
		case (style)
			STYLE_WIDE: return coord_t'($urandom_range(0, 16'hFFFF));
			STYLE_EDGE: begin
				case ($urandom_range(0, 3))
					0: return coord_t'(COORD_MAX);
					1: return coord_t'(COORD_MIN);
					2: return '0;
					default: return '1;
				endcase
			end
			default: begin
				v = int'(center) + int'($urandom_range(0, 2 * spread)) - spread;
				if (v > COORD_MAX)
					v = COORD_MAX;
				if (v < COORD_MIN)
					v = COORD_MIN;
				return coord_t'(v);
			end
		endcase
	endfunction

	task automatic send_random_patch();
		int           len;
		int           spread;
		int           pick;
		patch_style_t style;
		coord_t       c[3];
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
		pick = $urandom_range(0, 9);
		style = (pick < 6) ? STYLE_CLUSTER : (pick < 9) ? STYLE_WIDE : STYLE_EDGE;
		spread = $urandom_range(0, 1) ? $urandom_range(0, 64) : $urandom_range(0, 4000);
		for (int a = 0; a < 3; a++)
			c[a] = $urandom_range(0, 3) == 0 ? coord_t'($urandom) :
					coord_t'(int'($urandom_range(0, 50000)) - 25000);
		for (int k = 0; k < len; k++)
			send_vertex(pick_coord(style, c[0], spread), pick_coord(style, c[1], spread),
					pick_coord(style, c[2], spread), k == len - 1);
	endtask

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		vtx_valid <= 1'b0;
		vtx <= '0;
		hold_go = 1'b0;
		burst = 1'b0;
		send_fast = 1'b0;
		sent_vertices = 0;
		idle_cycles = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// planes at reset: everything visible
		send_vertex(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1);
		send_vertex(16'sh8000, 16'sh8000, 16'sh8000, 1'b1);
		send_vertex('0, '0, '0, 1'b0);
		send_vertex('1, '1, '1, 1'b1);
		send_vertex(16'sh8000, 16'sh7FFF, '0, 1'b0);
		send_vertex(16'sh7FFF, 16'sh8000, '1, 1'b1);

		settle();
		load_planes(PLANES_FRUSTUM, 1000);
		send_vertex('0, '0, '0, 1'b1);
		send_vertex(16'sd2000, '0, '0, 1'b1);
		send_vertex(-16'sd2000, '0, '0, 1'b1);
		send_vertex('0, 16'sd2000, '0, 1'b1);
		send_vertex('0, -16'sd2000, '0, 1'b1);
		send_vertex('0, '0, 16'sd2000, 1'b1);
		send_vertex('0, '0, -16'sd2000, 1'b1);
		send_vertex(-16'sd5000, '0, '0, 1'b0);
		send_vertex(16'sd5000, '0, '0, 1'b1);
		send_vertex(16'sd1000, -16'sd1000, 16'sd1000, 1'b1);

		settle();
		load_all({4{16'h8000}});
		send_vertex(16'sh8000, 16'sh8000, 16'sh8000, 1'b1);
		settle();
		load_all({4{16'h7FFF}});
		send_vertex(16'sh8000, 16'sh8000, 16'sh8000, 1'b1);
		settle();
		load_all('1);
		send_vertex('0, '0, '0, 1'b1);
		settle();
		load_all('0);
		write_reg(NUM_PLANES, '1);
		write_reg(NUM_ADDR_SLOTS - 1, '1);
		release_bus();
		send_vertex('0, '0, '0, 1'b1);

		while (sent_vertices < TARGET_VERTICES) begin
			settle();
			load_planes(plane_mix_t'($urandom_range(0, int'(PLANES_SPARSE))),
					$urandom_range(500, 20000));
			if (!hold_go && sent_vertices > TARGET_VERTICES / 3) begin
				hold_go = 1'b1;
				burst = 1'b1;
				repeat (80)
					send_vertex(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom), 1'b1);
				burst = 1'b0;
			end
			repeat ($urandom_range(8, 24))
				send_random_patch();
		end

		settle();
		if (tracker.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/pbfc_pkg.sv
rtl/pbfc_plane_test.sv
rtl/patch_bbox_frustum_cull.sv
dv/testbench.sv
